/* hw/rtl/assert_macros.svh */
// Assertion helpers; clock and reset names are fixed for the RTL tree.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BIM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define BIM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/bim_pkg.sv */
package bim_pkg;

   localparam int unsigned FLAT_W      = 64;
   localparam int unsigned NUM_DIMS    = 4;
   localparam int unsigned DIM_BITS    = 16;
   localparam int unsigned CSR_DATA_W  = DIM_BITS;
   localparam int unsigned CSR_IDX_W   = 4;
   localparam int unsigned REGS_PER_OP = 4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_A_SIZE_0 = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_B_SIZE_0 = CSR_IDX_W'(REGS_PER_OP);

   typedef logic [FLAT_W-1:0]     flat_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;

endpackage

/* hw/rtl/broadcast_index_mapper_top.sv */
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+------------------------------------------
// req      | in  | req_valid / req_stall  | req_flat_index
// rsp      | out | rsp_valid / rsp_stall  | rsp_offset_a, rsp_offset_b,
//          |     |                        | rsp_shapes_incompatible, rsp_index_out_of_range
// csr      | in  | csr_wr_en              | csr_index, csr_data
//
// One transfer per cycle sustained while the output is not stalled. An accepted
// request passes an input register, then for each dimension a 64-stage
// restoring divider, one quotient bit per stage, then a multiply stage and an
// accumulate stage, and last the output register that drives rsp_valid.
// Reset (synchronous) sets all sizes to 1 and clears every stage valid bit.
// The whole pipe holds while the output register is full and stalled;
// req_stall mirrors that, so nothing is dropped or repeated.
// Derived shape data (strides, flags) is registered, so it lags a size write.
`include "assert_macros.svh"

module broadcast_index_mapper_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bim_pkg::flat_type     req_flat_index,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bim_pkg::flat_type     rsp_offset_a,
   output bim_pkg::flat_type     rsp_offset_b,
   output logic                  rsp_shapes_incompatible,
   output logic                  rsp_index_out_of_range,
   input  logic                  csr_wr_en,
   input  bim_pkg::csr_idx_type  csr_index,
   input  bim_pkg::csr_data_type csr_data
);
   import bim_pkg::*;

   localparam int unsigned DIV_STAGES = FLAT_W;
   localparam int unsigned DIM_STAGES = DIV_STAGES + 2;
   localparam int unsigned NSTAGE     = 1 + NUM_DIMS * DIM_STAGES;
   localparam int unsigned PROD_W     = DIM_BITS + 32;

   typedef logic [DIM_BITS-1:0] dim_type;

   typedef struct packed {
      logic              vld;
      logic [FLAT_W-1:0] num;    // dividend bits out, quotient bits in
      dim_type           rem;
      logic [FLAT_W-1:0] off_a;
      logic [FLAT_W-1:0] off_b;
      logic [PROD_W-1:0] pa_lo;
      logic [PROD_W-1:0] pa_hi;
      logic [PROD_W-1:0] pb_lo;
      logic [PROD_W-1:0] pb_hi;
   } stage_type;

   // ---------------- shape registers ----------------
   dim_type           a_size_ff [NUM_DIMS];
   dim_type           b_size_ff [NUM_DIMS];
   dim_type           res_size  [NUM_DIMS];
   logic [FLAT_W-1:0] stride_a_ff [NUM_DIMS];
   logic [FLAT_W-1:0] stride_b_ff [NUM_DIMS];
   logic              incompat_ff;
   logic              has_zero_ff;
   logic              incompat_in;
   logic              has_zero_in;

   always_ff @(posedge clock) begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (reset) begin
            a_size_ff[d] <= dim_type'(1);
            b_size_ff[d] <= dim_type'(1);
         end else if (csr_wr_en && d < REGS_PER_OP) begin
            if (csr_index == CSR_A_SIZE_0 + CSR_IDX_W'(d)) begin
               a_size_ff[d] <= DIM_BITS'(csr_data);
            end
            if (csr_index == CSR_B_SIZE_0 + CSR_IDX_W'(d)) begin
               b_size_ff[d] <= DIM_BITS'(csr_data);
            end
         end
      end
   end

   always_comb begin
      incompat_in = 1'b0;
      has_zero_in = 1'b0;
      for (int d = 0; d < NUM_DIMS; d++) begin
         res_size[d] = (a_size_ff[d] > b_size_ff[d]) ? a_size_ff[d] : b_size_ff[d];
         if (!(a_size_ff[d] == b_size_ff[d] || a_size_ff[d] == dim_type'(1) ||
               b_size_ff[d] == dim_type'(1))) begin
            incompat_in = 1'b1;
         end
         if (res_size[d] == '0) begin
            has_zero_in = 1'b1;
         end
      end
   end

   // stride chain: one 64x DIM_BITS product per register
   always_ff @(posedge clock) begin
      incompat_ff       <= incompat_in;
      has_zero_ff       <= has_zero_in;
      stride_a_ff[0]    <= FLAT_W'(1);
      stride_b_ff[0]    <= FLAT_W'(1);
      for (int d = 1; d < NUM_DIMS; d++) begin
         stride_a_ff[d] <= FLAT_W'(stride_a_ff[d-1] * FLAT_W'(a_size_ff[d-1]));
         stride_b_ff[d] <= FLAT_W'(stride_b_ff[d-1] * FLAT_W'(b_size_ff[d-1]));
      end
   end

   // ---------------- stage functions ----------------
   function automatic stage_type div_step(input stage_type p, input dim_type r,
                                          input logic first);
      stage_type           o;
      logic [DIM_BITS:0]   t;
      logic                q;
      o = p;
      t = {(first ? dim_type'(0) : p.rem), p.num[FLAT_W-1]};
      q = (t >= {1'b0, r});
      o.rem = q ? DIM_BITS'(t - {1'b0, r}) : t[DIM_BITS-1:0];
      o.num = {p.num[FLAT_W-2:0], q};
      return o;
   endfunction

   function automatic stage_type mul_step(input stage_type p, input dim_type r,
                                          input dim_type sa, input dim_type sb,
                                          input logic [FLAT_W-1:0] st_a,
                                          input logic [FLAT_W-1:0] st_b);
      stage_type o;
      dim_type   ia;
      dim_type   ib;
      o  = p;
      ia = (sa == r) ? p.rem : '0;
      ib = (sb == r) ? p.rem : '0;
      o.pa_lo = PROD_W'(ia) * PROD_W'(st_a[31:0]);
      o.pa_hi = PROD_W'(ia) * PROD_W'(st_a[63:32]);
      o.pb_lo = PROD_W'(ib) * PROD_W'(st_b[31:0]);
      o.pb_hi = PROD_W'(ib) * PROD_W'(st_b[63:32]);
      return o;
   endfunction

   function automatic stage_type acc_step(input stage_type p);
      stage_type o;
      o = p;
      o.off_a = p.off_a + FLAT_W'(p.pa_lo) + (FLAT_W'(p.pa_hi) << 32);
      o.off_b = p.off_b + FLAT_W'(p.pb_lo) + (FLAT_W'(p.pb_hi) << 32);
      return o;
   endfunction

   // ---------------- pipeline ----------------
   stage_type st_ff [NSTAGE];
   stage_type st_in [NSTAGE];
   logic      adv;
   logic      rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_comb begin
      st_in[0]       = '0;
      st_in[0].vld   = req_valid;
      st_in[0].num   = req_flat_index;
   end

   for (genvar i = 1; i < NSTAGE; i++) begin : g_stage
      localparam int unsigned J = i - 1;
      localparam int unsigned D = J / DIM_STAGES;
      localparam int unsigned S = J % DIM_STAGES;
      if (S < DIV_STAGES) begin : g_div
         assign st_in[i] = div_step(st_ff[i-1], res_size[D], S == 0);
      end else if (S == DIV_STAGES) begin : g_mul
         assign st_in[i] = mul_step(st_ff[i-1], res_size[D], a_size_ff[D], b_size_ff[D],
                                    stride_a_ff[D], stride_b_ff[D]);
      end else begin : g_acc
         assign st_in[i] = acc_step(st_ff[i-1]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NSTAGE; i++) begin
         if (reset) begin
            st_ff[i].vld <= 1'b0;
         end else if (adv) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   // ---------------- output register ----------------
   flat_type rsp_offset_a_ff;
   flat_type rsp_offset_b_ff;
   logic     rsp_incompat_ff;
   logic     rsp_oor_ff;
   logic     oor_in;

   // quotient left after all dimensions is nonzero exactly when the index
   // reaches the element count; a zero dimension makes every index overflow
   assign oor_in = has_zero_ff || (st_ff[NSTAGE-1].num != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= st_ff[NSTAGE-1].vld;
      end
      if (adv) begin
         rsp_incompat_ff <= incompat_ff;
         rsp_oor_ff      <= oor_in;
         rsp_offset_a_ff <= (incompat_ff || oor_in) ? '0 : st_ff[NSTAGE-1].off_a;
         rsp_offset_b_ff <= (incompat_ff || oor_in) ? '0 : st_ff[NSTAGE-1].off_b;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_offset_a            = rsp_offset_a_ff;
   assign rsp_offset_b            = rsp_offset_b_ff;
   assign rsp_shapes_incompatible = rsp_incompat_ff;
   assign rsp_index_out_of_range  = rsp_oor_ff;

   // ---------------- assertions ----------------
   logic rsp_flagged;
   logic rsp_offs_zero;
   logic req_xfer;
   logic tail_move;

   assign rsp_flagged   = rsp_valid_ff && (rsp_incompat_ff || rsp_oor_ff);
   assign rsp_offs_zero = (rsp_offset_a_ff == '0) && (rsp_offset_b_ff == '0);
   assign req_xfer      = req_valid && !req_stall;
   assign tail_move     = adv && st_ff[NSTAGE-1].vld;

   `BIM_ASSERT_NOW(a_flag_zero_offs, rsp_flagged, rsp_offs_zero, "flagged result nonzero offset")
   `BIM_ASSERT_NXT(a_accept_enters, req_xfer, st_ff[0].vld, "accepted transfer not in pipe")
   `BIM_ASSERT_NXT(a_tail_to_out, tail_move, rsp_valid_ff, "pipe tail lost at output")

endmodule
